>>> sv/overlapped_block_mean_square_gate_macros.svh
`ifndef OVERLAPPED_BLOCK_MEAN_SQUARE_GATE_MACROS_SVH
`define OVERLAPPED_BLOCK_MEAN_SQUARE_GATE_MACROS_SVH

// same-cycle implication, held off during reset
`define OBMSG_ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("obmsg: same-cycle check failed");

// next-cycle implication, held off during reset
`define OBMSG_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("obmsg: next-cycle check failed");

`endif

>>> sv/obmsg_pkg.sv
package obmsg_pkg;

  localparam int Partition = 4;
  localparam int SlotW     = (Partition > 1) ? $clog2(Partition) : 1;
  localparam int UseW      = $clog2(Partition + 1);

  localparam int HopW      = 16;
  localparam int ScaleW    = 32;
  localparam int EnergyW   = 32;
  localparam int AccW      = 48;
  localparam int ProdW     = 64;
  localparam int ProdShift = 16;

  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 48;

  localparam logic [HopW-1:0]   HopLengthReset  = HopW'(4800);
  localparam logic [ScaleW-1:0] BlockScaleReset = ScaleW'(223696);
  localparam logic [AccW-1:0]   GateLevelReset  = AccW'(2058000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_HOP_LENGTH  = 2'd0,
    REG_BLOCK_SCALE = 2'd1,
    REG_GATE_LEVEL  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [HopW-1:0]   hop_length;
    logic [ScaleW-1:0] block_scale;
    logic [AccW-1:0]   gate_level;
  } cfg_t;

  // scaled energy plus end-of-hop mark
  typedef struct packed {
    logic [AccW-1:0] add;
    logic            hop;
  } hop_word_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [FifoCntW-1:0] count;
  } fifo_status_t;

  typedef struct packed {
    logic ring_full;
  } back_status_t;

endpackage

>>> sv/obmsg_if.sv
interface obmsg_in_if;
  logic                           valid;
  logic                           ready;
  logic [obmsg_pkg::EnergyW-1:0]  sample_energy;

  modport source (output valid, output sample_energy, input ready);
  modport sink   (input valid, input sample_energy, output ready);
endinterface

interface obmsg_out_if;
  logic                        valid;
  logic                        ready;
  logic [obmsg_pkg::AccW-1:0]  block_mean_square;

  modport source (output valid, output block_mean_square, input ready);
  modport sink   (input valid, input block_mean_square, output ready);
endinterface

>>> sv/overlapped_block_mean_square_gate.sv
// Overlapped block mean-square gate. Takes one sample energy word (unsigned Q4.28)
// per cycle, sustained unless the output stalls and the two-word queue fills, and
// delivers a block mean square (Q4.44) each time a hop completes a full block whose
// value is strictly above gate_level. The rate is set by one 32x32 multiplier in the
// front stage and PARTITION parallel saturating 48-bit adders in the back stage; the
// queue between them lets the input and output sides stall on their own. An
// accepted word passes the front-stage register and the queue before the output
// register takes its result. Registers must be written through cfg_wr_en / cfg_index /
// cfg_wr_data only while the block is idle, which it does not enforce; index 3 is ignored.
`include "overlapped_block_mean_square_gate_macros.svh"

module overlapped_block_mean_square_gate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [obmsg_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [obmsg_pkg::CfgDataW-1:0]    cfg_wr_data,
  obmsg_in_if.sink                          samples,
  obmsg_out_if.source                       blocks
);

  obmsg_pkg::cfg_t            cfg;
  logic                       push;
  logic                       pop;
  logic                       front_busy;
  obmsg_pkg::hop_word_t       push_word;
  obmsg_pkg::hop_word_t       pop_word;
  obmsg_pkg::fifo_status_t    fifo_st;
  obmsg_pkg::back_status_t    back_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{hop_length:  obmsg_pkg::HopLengthReset,
               block_scale: obmsg_pkg::BlockScaleReset,
               gate_level:  obmsg_pkg::GateLevelReset};
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        obmsg_pkg::REG_HOP_LENGTH:  cfg.hop_length  <= cfg_wr_data[obmsg_pkg::HopW-1:0];
        obmsg_pkg::REG_BLOCK_SCALE: cfg.block_scale <= cfg_wr_data[obmsg_pkg::ScaleW-1:0];
        obmsg_pkg::REG_GATE_LEVEL:  cfg.gate_level  <= cfg_wr_data[obmsg_pkg::AccW-1:0];
        default: ;
      endcase
    end
  end

  obmsg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samples   (samples),
    .fifo_full (fifo_st.full),
    .push      (push),
    .push_word (push_word),
    .busy      (front_busy)
  );

  obmsg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .status    (fifo_st)
  );

  obmsg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_empty (fifo_st.empty),
    .pop_word   (pop_word),
    .pop        (pop),
    .blocks     (blocks),
    .status     (back_st)
  );

  `OBMSG_ASSERT_IMPLIES(a_emit_needs_full_ring, clk, rst, blocks.valid, back_st.ring_full)
  `OBMSG_ASSERT_IMPLIES(a_fifo_count_bound, clk, rst, 1'b1, fifo_st.count <= obmsg_pkg::FifoCntW'(obmsg_pkg::FifoDepth))
  `OBMSG_ASSERT_IMPLIES(a_front_backpressure, clk, rst, front_busy && fifo_st.full, !samples.ready)
  `OBMSG_ASSERT_NEXT(a_pop_frees_space, clk, rst, pop && !push, !fifo_st.full)

endmodule

>>> sv/obmsg_front.sv
module obmsg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  obmsg_pkg::cfg_t      cfg,
  obmsg_in_if.sink             samples,
  input  logic                 fifo_full,
  output logic                 push,
  output obmsg_pkg::hop_word_t push_word,
  output logic                 busy
);

  logic                             stage_valid;
  obmsg_pkg::hop_word_t             stage_word;
  logic [obmsg_pkg::HopW-1:0]       hop_counter;
  logic [obmsg_pkg::HopW-1:0]       hop_counter_next;
  logic [obmsg_pkg::ProdW-1:0]      product;
  logic                             hop_hit;
  logic                             accept;

  assign samples.ready = !stage_valid || !fifo_full;
  assign accept        = samples.valid && samples.ready;
  assign push          = stage_valid && !fifo_full;
  assign push_word     = stage_word;
  assign busy          = stage_valid;

  always_comb begin
    product          = obmsg_pkg::ProdW'(samples.sample_energy) *
                       obmsg_pkg::ProdW'(cfg.block_scale);
    hop_counter_next = hop_counter + obmsg_pkg::HopW'(1);
    hop_hit          = (hop_counter_next == cfg.hop_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      hop_counter <= '0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
        hop_counter <= hop_hit ? '0 : hop_counter_next;
      end else if (push) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_word <= '{add: product[obmsg_pkg::ProdShift +: obmsg_pkg::AccW], hop: hop_hit};
    end
  end

endmodule

>>> sv/obmsg_fifo.sv
module obmsg_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  obmsg_pkg::hop_word_t    push_word,
  input  logic                    pop,
  output obmsg_pkg::hop_word_t    pop_word,
  output obmsg_pkg::fifo_status_t status
);

  obmsg_pkg::hop_word_t                entries [obmsg_pkg::FifoDepth];
  logic [obmsg_pkg::FifoPtrW-1:0]      wr_ptr;
  logic [obmsg_pkg::FifoPtrW-1:0]      rd_ptr;
  logic [obmsg_pkg::FifoCntW-1:0]      count;
  logic                                do_push;
  logic                                do_pop;

  assign status.full  = (count == obmsg_pkg::FifoCntW'(obmsg_pkg::FifoDepth));
  assign status.empty = (count == '0);
  assign status.count = count;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_word     = entries[rd_ptr];

  function automatic logic [obmsg_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [obmsg_pkg::FifoPtrW-1:0] p
  );
    if (p == obmsg_pkg::FifoPtrW'(obmsg_pkg::FifoDepth - 1)) begin
      return '0;
    end
    return p + obmsg_pkg::FifoPtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + obmsg_pkg::FifoCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - obmsg_pkg::FifoCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_word;
  end

endmodule

>>> sv/obmsg_back.sv
module obmsg_back (
  input  logic                    clk,
  input  logic                    rst,
  input  obmsg_pkg::cfg_t         cfg,
  input  logic                    fifo_empty,
  input  obmsg_pkg::hop_word_t    pop_word,
  output logic                    pop,
  obmsg_out_if.source             blocks,
  output obmsg_pkg::back_status_t status
);

  logic [obmsg_pkg::AccW-1:0]  acc      [obmsg_pkg::Partition];
  logic [obmsg_pkg::AccW-1:0]  acc_sum  [obmsg_pkg::Partition];
  logic [obmsg_pkg::AccW-1:0]  acc_next [obmsg_pkg::Partition];
  logic [obmsg_pkg::AccW:0]    wide_sum [obmsg_pkg::Partition];
  logic [obmsg_pkg::SlotW-1:0] newest_slot;
  logic [obmsg_pkg::SlotW-1:0] next_slot;
  logic [obmsg_pkg::UseW-1:0]  slots_in_use;
  logic                        ring_full;
  logic [obmsg_pkg::AccW-1:0]  done;
  logic                        emit;

  assign pop              = !fifo_empty && (!blocks.valid || blocks.ready);
  assign ring_full        = (slots_in_use == obmsg_pkg::UseW'(obmsg_pkg::Partition));
  assign status.ring_full = ring_full;

  always_comb begin
    for (int i = 0; i < obmsg_pkg::Partition; i++) begin
      wide_sum[i] = {1'b0, acc[i]} + {1'b0, pop_word.add};
      if (obmsg_pkg::UseW'(i) < slots_in_use) begin
        acc_sum[i] = wide_sum[i][obmsg_pkg::AccW] ? '1 : wide_sum[i][obmsg_pkg::AccW-1:0];
      end else begin
        acc_sum[i] = acc[i];
      end
    end
    if (newest_slot == obmsg_pkg::SlotW'(obmsg_pkg::Partition - 1)) begin
      next_slot = '0;
    end else begin
      next_slot = newest_slot + obmsg_pkg::SlotW'(1);
    end
    done = acc_sum[next_slot];
    emit = pop && pop_word.hop && ring_full && (done > cfg.gate_level);
    // slot after the newest is cleared at end of hop
    for (int i = 0; i < obmsg_pkg::Partition; i++) begin
      if (pop_word.hop && (obmsg_pkg::SlotW'(i) == next_slot)) begin
        acc_next[i] = '0;
      end else begin
        acc_next[i] = acc_sum[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < obmsg_pkg::Partition; i++) acc[i] <= '0;
      newest_slot  <= '0;
      slots_in_use <= obmsg_pkg::UseW'(1);
      blocks.valid <= 1'b0;
    end else begin
      if (pop) begin
        for (int i = 0; i < obmsg_pkg::Partition; i++) acc[i] <= acc_next[i];
        if (pop_word.hop) begin
          newest_slot <= next_slot;
          if (!ring_full) slots_in_use <= slots_in_use + obmsg_pkg::UseW'(1);
        end
      end
      if (emit) begin
        blocks.valid <= 1'b1;
      end else if (blocks.ready) begin
        blocks.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) blocks.block_mean_square <= done;
  end

endmodule
